>>> src/sidt_pkg.sv
// Shared types, codes and defaults for the sorted id table.
`default_nettype none
package sidt_pkg;
  localparam int DEFAULT_DEPTH = 16;
  localparam logic [4:0] DEFAULT_CAPACITY = 5'd16;
  localparam logic [31:0] DEFAULT_DELAY_MS = 32'd5000;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_DELAY    = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] entry_id;
    logic [63:0] entry_address;
    logic [63:0] now_ms;
  } sidt_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_address;
    logic        published;
    logic [31:0] snapshot_version;
    logic [4:0]  entry_count;
  } sidt_res_t;
endpackage
`default_nettype wire

>>> src/sorted_id_table_with_versioned_snapshot.sv
// Top level: input queue, sorted table back end and result queue.
// Each beat takes two table steps: one registers the id compare against every cell, one
// shifts, updates and reports. Input and result queues of two beats decouple neighbors, so
// a new beat may be pushed while a result waits. Results come out in order, one per beat.
`default_nettype none
module sorted_id_table_with_versioned_snapshot
  import sidt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [63:0] in_entry_id,
  input  wire logic [63:0] in_entry_address,
  input  wire logic [63:0] in_now_ms,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_status,
  output logic [63:0]      out_found_address,
  output logic             out_published,
  output logic [31:0]      out_snapshot_version,
  output logic [4:0]       out_entry_count,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [4:0] cap_r;
  logic [31:0] delay_r;
  sidt_cmd_t in_cmd, q_cmd;
  sidt_res_t res, out_res;
  logic q_empty, take, res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= DEFAULT_CAPACITY;
      delay_r <= DEFAULT_DELAY_MS;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CAPACITY) cap_r <= cfg_data[4:0];
      else delay_r <= cfg_data;
    end
  end

  assign in_cmd = '{opcode: in_opcode, entry_id: in_entry_id,
                    entry_address: in_entry_address, now_ms: in_now_ms};

  sidt_fifo #(.WIDTH($bits(sidt_cmd_t)), .DEPTH(2)) u_inq (
    .clk, .rst_n, .push(in_push), .wdata(in_cmd), .full(in_full),
    .pop(take), .rdata(q_cmd), .empty(q_empty));

  sidt_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk, .rst_n, .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(take),
    .capacity(cap_r), .delay_ms(delay_r), .res_push, .res, .res_full);

  sidt_fifo #(.WIDTH($bits(sidt_res_t)), .DEPTH(2)) u_outq (
    .clk, .rst_n, .push(res_push), .wdata(res), .full(res_full),
    .pop(out_pop), .rdata(out_res), .empty(out_empty));

  assign out_status = out_res.status;
  assign out_found_address = out_res.found_address;
  assign out_published = out_res.published;
  assign out_snapshot_version = out_res.snapshot_version;
  assign out_entry_count = out_res.entry_count;
endmodule
`default_nettype wire

>>> src/sidt_fifo.sv
// Small first-in first-out queue of registers, used between the stages.
`default_nettype none
module sidt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_push, do_pop;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule
`default_nettype wire

>>> src/sidt_table.sv
// Back end: sorted shift-cell table, snapshot and publish logic.
`default_nettype none
module sidt_table
  import sidt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  input  wire sidt_cmd_t   cmd,
  output logic             cmd_take,
  input  wire logic [4:0]  capacity,
  input  wire logic [31:0] delay_ms,
  output logic             res_push,
  output sidt_res_t        res,
  input  wire logic        res_full
);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] ids_r [TABLE_DEPTH];
  logic [63:0] addrs_r [TABLE_DEPTH];
  logic [63:0] snap_ids_r [TABLE_DEPTH];
  logic [63:0] snap_addrs_r [TABLE_DEPTH];
  logic [CW-1:0] count_r, snap_count_r;
  logic dirty_r;
  logic [63:0] stamp_r, last_tick_r;
  logic [31:0] version_r;

  // Stage one registers per-cell compare results, stage two applies them.
  logic busy_r;
  sidt_cmd_t cmd_r;
  logic [TABLE_DEPTH-1:0] lt_r, eq_r;

  logic [TABLE_DEPTH-1:0] valid_cell;
  logic [CW-1:0] cap_eff;
  logic hit, full_now, do_ins, do_rem, do_pub;
  logic [63:0] hit_addr, elapsed;
  logic [31:0] ver_inc;
  sidt_res_t res_c;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) valid_cell[i] = (CW'(i) < count_r);
  end

  assign cap_eff = (32'(capacity) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(capacity);
  assign hit = |(eq_r & valid_cell);
  always_comb begin
    hit_addr = '0;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (eq_r[i] && valid_cell[i]) hit_addr = addrs_r[i];
  end
  assign full_now = (count_r >= cap_eff);
  assign elapsed  = cmd_r.now_ms - stamp_r;
  assign do_ins = busy_r && cmd_r.opcode == OP_INSERT && !full_now && !hit;
  assign do_rem = busy_r && cmd_r.opcode == OP_REMOVE && hit;
  assign do_pub = busy_r && cmd_r.opcode == OP_TICK && dirty_r && (elapsed > 64'(delay_ms));
  assign ver_inc = (version_r + 32'd1 == '0) ? 32'd1 : version_r + 32'd1;

  assign cmd_take = cmd_valid && !busy_r;
  assign res_push = busy_r && !res_full;

  always_comb begin
    res_c = '0;
    res_c.status = ST_OK;
    case (cmd_r.opcode)
      OP_INSERT: if (full_now) res_c.status = ST_FULL;
                 else if (hit) res_c.status = ST_DUP;
      OP_REMOVE: if (!hit) res_c.status = ST_MISSING;
      OP_LOOKUP: if (hit) res_c.found_address = hit_addr;
                 else res_c.status = ST_MISSING;
      default: res_c.published = do_pub;
    endcase
    res_c.snapshot_version = do_pub ? ver_inc : version_r;
    res_c.entry_count = 5'(count_r + CW'(do_ins) - CW'(do_rem));
  end
  assign res = res_c;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_r <= cmd;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        lt_r[i] <= ids_r[i] < cmd.entry_id;
        eq_r[i] <= ids_r[i] == cmd.entry_id;
      end
    end
    if (res_push) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (do_ins) begin
          if (!(lt_r[i] && valid_cell[i])) begin
            if (i == 0 || (lt_r[(i == 0) ? 0 : i-1] && valid_cell[(i == 0) ? 0 : i-1])) begin
              ids_r[i] <= cmd_r.entry_id;
              addrs_r[i] <= cmd_r.entry_address;
            end else begin
              ids_r[i] <= ids_r[(i == 0) ? 0 : i-1];
              addrs_r[i] <= addrs_r[(i == 0) ? 0 : i-1];
            end
          end
        end else if (do_rem) begin
          if (!(lt_r[i] && valid_cell[i]) && i < TABLE_DEPTH-1) begin
            ids_r[i] <= ids_r[(i < TABLE_DEPTH-1) ? i+1 : i];
            addrs_r[i] <= addrs_r[(i < TABLE_DEPTH-1) ? i+1 : i];
          end
        end
        if (do_pub) begin
          snap_ids_r[i] <= ids_r[i];
          snap_addrs_r[i] <= addrs_r[i];
        end
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      count_r <= '0;
      snap_count_r <= '0;
      dirty_r <= 1'b0;
      stamp_r <= '0;
      last_tick_r <= '0;
      version_r <= '0;
    end else begin
      if (cmd_take) busy_r <= 1'b1;
      else if (res_push) busy_r <= 1'b0;
      if (res_push) begin
        count_r <= count_r + CW'(do_ins) - CW'(do_rem);
        if (do_ins) begin
          stamp_r <= last_tick_r;
          dirty_r <= 1'b1;
        end
        if (do_rem) dirty_r <= 1'b1;
        if (cmd_r.opcode == OP_TICK) last_tick_r <= cmd_r.now_ms;
        if (do_pub) begin
          version_r <= ver_inc;
          snap_count_r <= count_r;
          stamp_r <= cmd_r.now_ms;
          dirty_r <= 1'b0;
        end
      end
    end
  end

  // The snapshot is kept for a reader outside this table; nothing here reads it back.
  logic unused_snap;
  assign unused_snap = ^{snap_count_r, snap_ids_r[0], snap_addrs_r[0]};
endmodule
`default_nettype wire

>>> verif/sorted_id_table_with_versioned_snapshot_tb.sv
// Self-checking testbench for the sorted id table with versioned snapshot.
module sorted_id_table_with_versioned_snapshot_tb;
  import sidt_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Predicts the table and keeps the expected result beats in order.
  class table_scoreboard;
    logic [63:0] ids[DEPTH];
    logic [63:0] addrs[DEPTH];
    int count;
    bit dirty;
    logic [63:0] stamp_ms;
    logic [63:0] tick_ms;
    logic [31:0] version;
    logic [4:0] capacity;
    logic [31:0] delay_ms;
    sidt_res_t pending[$];
    int errors;
    int publishes;

    function new();
      count = 0; dirty = 0; stamp_ms = 0; tick_ms = 0; version = 0;
      capacity = DEFAULT_CAPACITY; delay_ms = DEFAULT_DELAY_MS;
      errors = 0; publishes = 0;
    endfunction

    function void note_config(logic idx, logic [31:0] data);
      if (idx == CFG_CAPACITY) capacity = data[4:0];
      else delay_ms = data;
    endfunction

    function bit holds(logic [63:0] id);
      for (int i = 0; i < count; i++) if (ids[i] == id) return 1;
      return 0;
    endfunction

    function void note_command(sidt_cmd_t c);
      sidt_res_t r;
      int cap;
      int pos;
      bit hit;
      r = '0;
      cap = (capacity > DEPTH) ? DEPTH : capacity;
      pos = 0;
      while (pos < count && ids[pos] < c.entry_id) pos++;
      hit = (pos < count) && (ids[pos] == c.entry_id);
      case (c.opcode)
        OP_INSERT: begin
          if (count >= cap) r.status = ST_FULL;
          else if (hit) r.status = ST_DUP;
          else begin
            for (int i = count; i > pos; i--) begin
              ids[i] = ids[i-1]; addrs[i] = addrs[i-1];
            end
            ids[pos] = c.entry_id; addrs[pos] = c.entry_address;
            count++; stamp_ms = tick_ms; dirty = 1;
          end
        end
        OP_REMOVE: begin
          if (hit) begin
            for (int i = pos; i + 1 < count; i++) begin
              ids[i] = ids[i+1]; addrs[i] = addrs[i+1];
            end
            count--; dirty = 1;
          end else r.status = ST_MISSING;
        end
        OP_LOOKUP: begin
          if (hit) r.found_address = addrs[pos];
          else r.status = ST_MISSING;
        end
        default: begin
          tick_ms = c.now_ms;
          if (dirty && (c.now_ms - stamp_ms) > {32'd0, delay_ms}) begin
            version = version + 1;
            if (version == 0) version = 1;
            stamp_ms = c.now_ms; dirty = 0; r.published = 1; publishes++;
          end
        end
      endcase
      r.snapshot_version = version;
      r.entry_count = count[4:0];
      pending = {pending, r};
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task automatic check_result(sidt_res_t got);
      sidt_res_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.found_address !== want.found_address)
        report("found_address", got.found_address, want.found_address);
      if (got.published !== want.published) report("published", got.published, want.published);
      if (got.snapshot_version !== want.snapshot_version)
        report("snapshot_version", got.snapshot_version, want.snapshot_version);
      if (got.entry_count !== want.entry_count)
        report("entry_count", got.entry_count, want.entry_count);
    endtask
  endclass

  logic clk, rst_n;
  logic in_push, in_full;
  logic [1:0] in_opcode;
  logic [63:0] in_entry_id, in_entry_address, in_now_ms;
  logic out_empty, out_pop;
  logic [1:0] out_status;
  logic [63:0] out_found_address;
  logic out_published;
  logic [31:0] out_snapshot_version;
  logic [4:0] out_entry_count;
  logic cfg_we, cfg_index;
  logic [31:0] cfg_data;

  sorted_id_table_with_versioned_snapshot uut (.*);

  table_scoreboard sb;
  int idle_cycles;
  int accepted;
  int results_seen;
  bit stall_mode;
  logic [63:0] clock_ms;
  logic [63:0] id_pool[8];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: alternates between stretches of free flow and stretches of random stalls.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0; stall_left <= 0; stall_mode <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        sb.check_result({out_status, out_found_address, out_published,
                         out_snapshot_version, out_entry_count});
        results_seen++;
      end
      if (stall_left == 0) begin
        stall_mode <= ~stall_mode;
        stall_left <= $urandom_range(5, 60);
      end else stall_left <= stall_left - 1;
      out_pop <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[sorted_id_table_with_versioned_snapshot] ERROR");
      $finish;
    end
  end

  task automatic send_cmd(logic [1:0] op, logic [63:0] id, logic [63:0] addr,
                          logic [63:0] now);
    sidt_cmd_t c;
    c = {op, id, addr, now};
    in_push <= 1; in_opcode <= op; in_entry_id <= id;
    in_entry_address <= addr; in_now_ms <= now;
    do @(posedge clk); while (in_full);
    sb.note_command(c);
    accepted++;
  endtask

  task automatic end_burst();
    in_push <= 0;
  endtask

  task automatic drain();
    in_push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] data);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.note_config(idx, data);
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly ids from a small pool so that duplicates, removes and hits are common.
  task automatic random_cmd();
    logic [1:0] op;
    logic [63:0] id;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_INSERT;
    else if (r < 60) op = OP_REMOVE;
    else if (r < 80) op = OP_LOOKUP;
    else op = OP_TICK;
    id = ($urandom_range(0, 9) < 8) ? id_pool[$urandom_range(0, 7)] : rand64();
    if (op == OP_TICK) begin
      if ($urandom_range(0, 19) == 0) clock_ms = rand64();
      else clock_ms = clock_ms + $urandom_range(0, 400);
    end
    send_cmd(op, id, rand64(), (op == OP_TICK) ? clock_ms : rand64());
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && n > 0; i++) begin
        random_cmd();
        n--;
      end
      end_burst();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    accepted = 0; results_seen = 0; idle_cycles = 0; clock_ms = 0;
    rst_n = 0; in_push = 0; in_opcode = OP_INSERT; in_entry_id = 0;
    in_entry_address = 0; in_now_ms = 0; cfg_we = 0; cfg_index = CFG_CAPACITY; cfg_data = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extreme ids and addresses, duplicates, misses, wrap and publish.
    send_cmd(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_cmd(OP_INSERT, 64'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(OP_INSERT, 64'h8000_0000_0000_0000, 64'h5555_AAAA_5555_AAAA, 0);
    send_cmd(OP_INSERT, 64'd0, 64'd1, 0);
    send_cmd(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_cmd(OP_LOOKUP, 64'd0, 0, 0);
    send_cmd(OP_LOOKUP, 64'd7, 0, 0);
    send_cmd(OP_TICK, 0, 0, 64'd5000);
    send_cmd(OP_TICK, 0, 0, 64'd5001);
    send_cmd(OP_REMOVE, 64'h8000_0000_0000_0000, 0, 0);
    send_cmd(OP_REMOVE, 64'h8000_0000_0000_0000, 0, 0);
    send_cmd(OP_TICK, 0, 0, 64'd3);
    send_cmd(OP_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
    send_cmd(OP_REMOVE, 64'd0, 0, 0);
    for (int i = 0; i < 8; i++) send_cmd(OP_INSERT, 64'd100 - i, i, 0);
    drain();

    // Capacity zero refuses every insert; delay zero publishes pending changes on any later tick.
    write_cfg(CFG_CAPACITY, 32'd0);
    write_cfg(CFG_DELAY, 32'd0);
    send_cmd(OP_INSERT, 64'd5, 64'd5, 0);
    send_cmd(OP_TICK, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    for (int i = 0; i < 8; i++) id_pool[i] = rand64();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin write_cfg(CFG_CAPACITY, 32'd31); write_cfg(CFG_DELAY, 32'd100); end
        1: begin write_cfg(CFG_CAPACITY, 32'd4); write_cfg(CFG_DELAY, 32'hFFFF_FFFF); end
        2: begin write_cfg(CFG_CAPACITY, 32'd16); write_cfg(CFG_DELAY, 32'd0); end
        3: begin write_cfg(CFG_CAPACITY, 32'd1); write_cfg(CFG_DELAY, 32'd250); end
        4: begin write_cfg(CFG_CAPACITY, 32'd17); write_cfg(CFG_DELAY, 32'd5000); end
        default: begin
          write_cfg(CFG_CAPACITY, $urandom_range(0, 31)); write_cfg(CFG_DELAY, $urandom_range(0, 600));
        end
      endcase
      for (int i = 0; i < 8; i++) if ($urandom_range(0, 1)) id_pool[i] = rand64();
      random_phase(320);
      drain();
    end

    $display("covered %0d commands and %0d results, %0d snapshot publishes, six register settings",
             accepted, results_seen, sb.publishes);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[sorted_id_table_with_versioned_snapshot] OK");
    else
      $display("[sorted_id_table_with_versioned_snapshot] ERROR");
    $finish;
  end
endmodule
